[hw/rtl/mmwg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmwg_pkg
// Shared types, constants and the quarter-wave sine table of the
// multi-mode waveform generator.
// ----------------------------------------------------------------------------
package mmwg_pkg;

  // Buffer length is 2**SAMPLE_BITS; the sample index wraps there.
  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;

  localparam int STEP_W    = 32;
  localparam int AMP_W     = 15;
  localparam int SAMPLE_W  = 16;
  localparam int SINE_W    = 15;                    // table entries, 0 .. 32767
  localparam int SINE_QTR  = 1 << SINE_TABLE_BITS;
  localparam int SINE_TOP  = SINE_TABLE_BITS + 2;   // quadrant bits + table index
  localparam int SINE_ADDR_W = SINE_TABLE_BITS + 1;

  // Multiplier operands: a covers amplitude and amplitude*sine, b the
  // index ramp or the sine terms.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = (SAMPLE_BITS + 2 > SINE_W + 3) ? SAMPLE_BITS + 2 : SINE_W + 3;
  localparam int ACC_W   = MUL_A_W + MUL_B_W;

  localparam int SAW_SHIFT = SAMPLE_BITS + 1;
  localparam int TRI_SHIFT = SAMPLE_BITS;
  localparam int AM_SHIFT  = 2 * SINE_W + 1;
  // 1.0 + 0.5*sin in units of 2**-16
  localparam int AM_OFFSET = 1 << (SINE_W + 1);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    MODE_SQUARE   = 2'd0,
    MODE_SAW      = 2'd1,
    MODE_TRIANGLE = 2'd2,
    MODE_AM       = 2'd3
  } mode_t;

  typedef logic [2:0] reg_index_t;
  localparam reg_index_t REG_MODE          = 3'd0;
  localparam reg_index_t REG_AMPLITUDE     = 3'd1;
  localparam reg_index_t REG_SQUARE_STEP   = 3'd2;
  localparam reg_index_t REG_CARRIER_STEP  = 3'd3;
  localparam reg_index_t REG_MODULATOR_STEP = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_C,
    ST_READ_M,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef logic [SINE_QTR:0][SINE_W-1:0] sine_rom_t;

  // Taylor series in Q30, evaluated at elaboration only.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        prod;
    longint             sum;
    longint             v;
    for (int k = 0; k <= SINE_QTR; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = 0;
      for (int t = 0; t < 9; t++) begin
        if ((t % 2) == 0) sum = sum + longint'(term);
        else              sum = sum - longint'(term);
        prod = (term * x2) >> 30;
        // next term divides by (2t+2)(2t+3)
        unique case (t)
          0:       term = prod / 64'd6;
          1:       term = prod / 64'd20;
          2:       term = prod / 64'd42;
          3:       term = prod / 64'd72;
          4:       term = prod / 64'd110;
          5:       term = prod / 64'd156;
          6:       term = prod / 64'd210;
          7:       term = prod / 64'd272;
          default: term = prod / 64'd342;
        endcase
      end
      sum = longint'(int'(sum));
      v   = (sum + 64'sd16384) / 32768;
      if (v < 0)     v = 0;
      if (v > 32767) v = 32767;
      rom[k] = v[SINE_W-1:0];
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/multi_mode_waveform_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_mode_waveform_generator
// Square, sawtooth, triangle and AM sine samples, one per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the s_ channel (tdata bit 0 = restart) requests one
//   sample; the sample leaves on the m_ channel with tlast set on the final
//   index of the buffer. restart zeroes the index and all phases first.
//   Write the registers over cfg_valid/cfg_index/cfg_data only while idle;
//   the block itself does not enforce this. cfg_ready is always high.
// Sequencing:
//   A sample uses a single shared multiplier under a small sequencer and a
//   registered sine ROM read. Square goes straight to DONE, sawtooth and
//   triangle pass through MUL, and AM through READ_C, READ_M and MUL (two
//   ROM reads, two multiplies); DONE then loads the output register. One
//   item is in work at a time; s_tready is high only while the sequencer
//   is idle.
// Reset and stall:
//   rst (synchronous) restores the register defaults and zeroes index and
//   phases. A finished sample waits in the output register; the next item is
//   accepted meanwhile, and its result holds in the last step until the
//   receiver takes the previous one.
// ----------------------------------------------------------------------------
module multi_mode_waveform_generator
  import mmwg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // input requests
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,     // [0] restart, [7:1] zero
  // output samples
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [SAMPLE_W-1:0]      m_tdata,     // [15:0] sample
  output logic                     m_tlast,     // last_of_buffer
  // register writes
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire reg_index_t          cfg_index,
  input  wire logic [STEP_W-1:0]   cfg_data
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam logic signed [ACC_W-1:0] SAW_MASK = ACC_W'((64'd1 << SAW_SHIFT) - 64'd1);
  localparam logic signed [ACC_W-1:0] TRI_MASK = ACC_W'((64'd1 << TRI_SHIFT) - 64'd1);
  localparam logic signed [ACC_W-1:0] AM_MASK  = ACC_W'((64'd1 << AM_SHIFT) - 64'd1);
  localparam logic signed [ACC_W-1:0] ACC_ZERO = ACC_W'(0);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(32768);

  // configuration
  mode_t               mode;
  logic [AMP_W-1:0]    amplitude;
  logic [STEP_W-1:0]   square_step;
  logic [STEP_W-1:0]   carrier_step;
  logic [STEP_W-1:0]   modulator_step;

  // generator state
  logic [SAMPLE_BITS-1:0] sample_index;
  logic [PHASE_BITS-1:0]  square_acc;
  logic [PHASE_BITS-1:0]  carrier_acc;
  logic [PHASE_BITS-1:0]  modulator_acc;

  // snapshot of the item in work
  logic [SAMPLE_BITS-1:0] work_index;
  logic                   work_square;
  logic [SINE_TOP-1:0]    work_carrier;
  logic [SINE_TOP-1:0]    work_modulator;

  state_t state, state_next;
  logic   accept;
  logic   out_load;

  logic [SINE_TOP-1:0]             rom_phase;
  logic [SINE_ADDR_W-1:0]          rom_addr;
  logic [SINE_W-1:0]               rom_q;
  logic signed [SAMPLE_W-1:0]      sine_val;

  logic signed [MUL_A_W-1:0]       mul_a;
  logic signed [MUL_B_W-1:0]       mul_b;
  logic signed [ACC_W-1:0]         acc;
  logic signed [MUL_B_W-1:0]       ramp;
  logic signed [MUL_B_W-1:0]       ramp_abs;
  logic signed [ACC_W-1:0]         quot;
  logic signed [SAMPLE_W-1:0]      result;

  logic [SAMPLE_BITS-1:0] base_index;
  logic [PHASE_BITS-1:0]  base_square;
  logic [PHASE_BITS-1:0]  base_carrier;
  logic [PHASE_BITS-1:0]  base_modulator;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_SQUARE;
      amplitude      <= AMP_W'(16384);
      square_step    <= STEP_W'(42852281);
      carrier_step   <= STEP_W'(42852281);
      modulator_step <= STEP_W'(486958);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:           mode           <= mode_t'(cfg_data[1:0]);
        REG_AMPLITUDE:      amplitude      <= cfg_data[AMP_W-1:0];
        REG_SQUARE_STEP:    square_step    <= cfg_data;
        REG_CARRIER_STEP:   carrier_step   <= cfg_data;
        REG_MODULATOR_STEP: modulator_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (mode)
            MODE_SQUARE: state_next = ST_DONE;
            MODE_AM:     state_next = ST_READ_C;
            default:     state_next = ST_MUL;
          endcase
        end
      end
      ST_READ_C: state_next = ST_READ_M;
      ST_READ_M: state_next = ST_MUL;
      ST_MUL:    state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- index and phases
  always_comb begin
    base_index     = s_tdata[0] ? '0 : sample_index;
    base_square    = s_tdata[0] ? '0 : square_acc;
    base_carrier   = s_tdata[0] ? '0 : carrier_acc;
    base_modulator = s_tdata[0] ? '0 : modulator_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index  <= '0;
      square_acc    <= '0;
      carrier_acc   <= '0;
      modulator_acc <= '0;
    end else if (accept) begin
      sample_index  <= base_index + SAMPLE_BITS'(1);
      square_acc    <= base_square + PHASE_BITS'(square_step);
      carrier_acc   <= base_carrier + PHASE_BITS'(carrier_step);
      modulator_acc <= base_modulator + PHASE_BITS'(modulator_step);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work_index     <= base_index;
      work_square    <= base_square[PHASE_BITS-1];
      work_carrier   <= base_carrier[PHASE_BITS-1 -: SINE_TOP];
      work_modulator <= base_modulator[PHASE_BITS-1 -: SINE_TOP];
    end
  end

  // ---------------------------------------------------------------- sine ROM
  // READ_C addresses the carrier, READ_M the modulator; data is registered into rom_q.
  always_comb begin
    rom_phase = (state == ST_READ_C) ? work_carrier : work_modulator;
    if (rom_phase[SINE_TOP-2])
      rom_addr = SINE_ADDR_W'(SINE_QTR) - {1'b0, rom_phase[SINE_TABLE_BITS-1:0]};
    else
      rom_addr = {1'b0, rom_phase[SINE_TABLE_BITS-1:0]};
  end

  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[rom_addr];
  end

  // quadrant of the value now in rom_q: carrier in READ_M, modulator in MUL
  always_comb begin
    logic neg;
    neg = (state == ST_READ_M) ? work_carrier[SINE_TOP-1] : work_modulator[SINE_TOP-1];
    sine_val = neg ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
  end

  // ---------------------------------------------------------------- shared multiplier
  always_comb begin
    ramp     = $signed(MUL_B_W'({work_index, 1'b0})) - MUL_B_W'(64'd1 << SAMPLE_BITS);
    ramp_abs = ramp[MUL_B_W-1] ? -ramp : ramp;
    mul_a    = $signed(MUL_A_W'(amplitude));
    mul_b    = ramp;
    if (state == ST_READ_M) begin
      mul_b = MUL_B_W'(sine_val);
    end else begin
      unique case (mode)
        MODE_AM: begin
          mul_a = acc[MUL_A_W-1:0];
          mul_b = MUL_B_W'(sine_val) + MUL_B_W'(AM_OFFSET);
        end
        MODE_TRIANGLE: mul_b = (ramp_abs <<< 1) - MUL_B_W'(64'd1 << SAMPLE_BITS);
        default:       mul_b = ramp;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ_M || state == ST_MUL) acc <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------- scale and clamp
  // shifts truncate toward zero: negative products get a bias first
  always_comb begin
    unique case (mode)
      MODE_SAW:      quot = (acc + (acc[ACC_W-1] ? SAW_MASK : ACC_ZERO)) >>> SAW_SHIFT;
      MODE_TRIANGLE: quot = (acc + (acc[ACC_W-1] ? TRI_MASK : ACC_ZERO)) >>> TRI_SHIFT;
      MODE_AM:       quot = (acc + (acc[ACC_W-1] ? AM_MASK : ACC_ZERO)) >>> AM_SHIFT;
      default:       quot = work_square ? ACC_W'(amplitude) : '0;
    endcase
    if (quot > SAT_HI)      result = SAMPLE_W'(SAT_HI);
    else if (quot < SAT_LO) result = SAMPLE_W'(SAT_LO);
    else                    result = quot[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= result;
      m_tlast <= (work_index == {SAMPLE_BITS{1'b1}});
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("accepted a second item while one is in work");

  a_index_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tdata[0]) |=> sample_index == $past(sample_index) + SAMPLE_BITS'(1))
    else $error("sample index did not advance by one");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tdata[0]) |=> (sample_index == SAMPLE_BITS'(1) &&
                                square_acc == PHASE_BITS'(square_step)))
    else $error("restart did not clear index and phase");

  a_square_level: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && mode == MODE_SQUARE) |->
      (m_tdata == '0 || m_tdata == SAMPLE_W'(amplitude)))
    else $error("square sample is neither zero nor amplitude");

  a_ramp_bound: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (mode == MODE_SAW || mode == MODE_TRIANGLE)) |->
      ($signed(m_tdata) <= $signed({1'b0, amplitude}) &&
       $signed(m_tdata) >= -$signed({1'b0, amplitude})))
    else $error("ramp sample exceeds amplitude");
`endif

endmodule

`default_nettype wire
